>>> rtl/frame_average_spot_locator_assert.svh
// Assertion macros for the frame average spot locator.
// Users must have signals named clk and rst in scope; rst disables the check.
`ifndef FRAME_AVERAGE_SPOT_LOCATOR_ASSERT_SVH
`define FRAME_AVERAGE_SPOT_LOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FASL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define FASL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define FASL_ASSERT(label, prop, msg)
`define FASL_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

>>> rtl/fasl_pkg.sv
// Shared types and constants for the frame average spot locator.
// No dependencies.
package fasl_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_FRAMES = 255;

  localparam int PIX_W   = 16;
  localparam int SUM_W   = 24;
  localparam int FRAME_W = 8;
  localparam int DIM_W   = 11;
  localparam int COORD_W = 10;
  localparam int DIST_W  = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int RES_DEPTH  = 4;

  localparam logic [PIX_W-1:0]   THRESHOLD_RST = 16'd35767;
  localparam logic [FRAME_W-1:0] FRAMES_RST    = 8'd1;
  localparam logic [DIM_W-1:0]   DIM_RST       = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD    = 2'd0,
    REG_FRAME_COUNT  = 2'd1,
    REG_IMAGE_WIDTH  = 2'd2,
    REG_IMAGE_HEIGHT = 2'd3
  } cfg_reg_t;

  // per-word control flags that travel down the pipeline
  typedef struct packed {
    logic valid;
    logic first;  // first frame: store is written, not read
    logic last;   // last frame: brightness test applies
    logic eop;    // final word of the pose
  } pipe_ctl_t;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] spot_x;
    logic [COORD_W-1:0] spot_y;
    logic [DIST_W-1:0]  spot_distance;
  } result_t;

endpackage

>>> rtl/fasl_pixel_if.sv
// Pixel stream channel: valid/ready plus one 16-bit grey value.
// Depends on fasl_pkg.
interface fasl_pixel_if import fasl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

>>> rtl/fasl_result_if.sv
// Result channel: valid/ready plus found flag, spot position and distance.
// Depends on fasl_pkg.
interface fasl_result_if import fasl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [COORD_W-1:0] spot_x;
  logic [COORD_W-1:0] spot_y;
  logic [DIST_W-1:0]  spot_distance;

  modport source (output valid, output found, output spot_x, output spot_y,
                  output spot_distance, input ready);
  modport sink   (input valid, input found, input spot_x, input spot_y,
                  input spot_distance, output ready);
endinterface

>>> rtl/fasl_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on fasl_pkg.
interface fasl_cfg_if import fasl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/frame_average_spot_locator.sv
// Frame average spot locator.
// Channels: pixels (sink, 16-bit grey word per accepted pixel, raster order,
// frames back to back), spots (source, one result word per pose), cfg (sink,
// register index and data; always ready). Register 0 threshold, 1 frame count,
// 2 image width, 3 image height. A write restarts the pose.
// Throughput: one pixel per cycle while pixels.ready is high. Each pixel does
// one read and one write of the sum memory; the write port is used every cycle
// a pixel flows. After the final pixel of the last frame is accepted, the result
// word passes the read stage, accumulate stage, compare logic and queue write.
// Reset: registers return to threshold 35767, one frame, 1024 x 1024; the
// position, frame index and best candidate clear. The sum memory is not
// cleared: the first frame of every pose overwrites each entry it reads later.
// Stall: results wait in a four-word queue. pixels.ready drops only while four
// results are queued or in flight, so the receiver may stall for a while
// without losing a word.
// Depends on fasl_pkg, the channel interfaces and the assertion macro header.
`include "frame_average_spot_locator_assert.svh"
module frame_average_spot_locator import fasl_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
  input  logic clk,
  input  logic rst,
  fasl_pixel_if.sink    pixels,
  fasl_result_if.source spots,
  fasl_cfg_if.sink      cfg
);

  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMPW  = 14;
  localparam int PW    = $clog2(RES_DEPTH + 1);

  // configuration
  logic [PIX_W-1:0]   threshold;
  logic [FRAME_W-1:0] frame_count;
  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;
  logic               cfg_wr;

  // effective geometry
  logic [WW-1:0]      w_eff;
  logic [HW-1:0]      h_eff;
  logic [FRAME_W-1:0] n_eff;
  logic [XW-1:0]      half_w;
  logic [YW-1:0]      half_h;

  // position
  logic [XW-1:0]      col;
  logic [YW-1:0]      row;
  logic [FRAME_W-1:0] frame_idx;
  logic [AW-1:0]      addr;
  logic [AW-1:0]      row_base;
  logic               col_end, row_end, frame_end;
  logic               accept;

  // read stage
  pipe_ctl_t          s1_ctl;
  logic [AW-1:0]      s1_addr;
  logic [PIX_W-1:0]   s1_pix;
  logic [XW-1:0]      s1_x;
  logic [YW-1:0]      s1_y;
  logic [XW-1:0]      s1_dx;
  logic [YW-1:0]      s1_dy;

  logic [SUM_W-1:0]   sum;
  logic               push;
  result_t            push_data;
  logic [PW-1:0]      pending;
  logic               out_take;

  assign cfg.ready    = 1'b1;
  assign cfg_wr       = cfg.valid && cfg.ready;
  assign pixels.ready = (pending < PW'(RES_DEPTH));
  assign accept       = pixels.valid && pixels.ready;
  assign out_take     = spots.valid && spots.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RST;
      frame_count  <= FRAMES_RST;
      image_width  <= DIM_RST;
      image_height <= DIM_RST;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(cfg.index))
        REG_THRESHOLD:    threshold    <= cfg.data;
        REG_FRAME_COUNT:  frame_count  <= cfg.data[FRAME_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg.data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg.data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_eff = WW'(1);
    end else if (CMPW'(image_width) > CMPW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = HW'(1);
    end else if (CMPW'(image_height) > CMPW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(image_height);
    end
    if (frame_count == '0) begin
      n_eff = FRAME_W'(1);
    end else if (frame_count > FRAME_W'(MAX_FRAMES)) begin
      n_eff = FRAME_W'(MAX_FRAMES);
    end else begin
      n_eff = frame_count;
    end
    half_w    = XW'(w_eff >> 1);
    half_h    = YW'(h_eff >> 1);
    col_end   = (WW'(col) == w_eff - 1'b1);
    row_end   = (HW'(row) == h_eff - 1'b1);
    frame_end = (frame_idx == n_eff - 1'b1);
  end

  // raster position and memory address
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      col       <= '0;
      row       <= '0;
      frame_idx <= '0;
      addr      <= '0;
      row_base  <= '0;
    end else if (accept) begin
      if (!col_end) begin
        col  <= col + 1'b1;
        addr <= addr + 1'b1;
      end else begin
        col <= '0;
        if (!row_end) begin
          row      <= row + 1'b1;
          row_base <= row_base + AW'(MAX_WIDTH);
          addr     <= row_base + AW'(MAX_WIDTH);
        end else begin
          row       <= '0;
          row_base  <= '0;
          addr      <= '0;
          frame_idx <= frame_end ? '0 : frame_idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= addr;
    s1_pix  <= pixels.pixel;
    s1_x    <= col;
    s1_y    <= row;
    s1_dx   <= (col >= half_w) ? col - half_w : half_w - col;
    s1_dy   <= (row >= half_h) ? row - half_h : half_h - row;
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl.valid <= accept;
      s1_ctl.first <= (frame_idx == '0);
      s1_ctl.last  <= frame_end;
      s1_ctl.eop   <= col_end && row_end && frame_end;
    end
  end

  // results queued or still in the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + PW'(accept && col_end && row_end && frame_end)
                         - PW'(out_take);
    end
  end

  fasl_sum_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rd_en    (accept),
    .rd_addr  (addr),
    .wr_valid (s1_ctl.valid),
    .wr_first (s1_ctl.first),
    .wr_addr  (s1_addr),
    .wr_pix   (s1_pix),
    .sum      (sum)
  );

  fasl_spot_track #(
    .XW (XW),
    .YW (YW)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .restart   (cfg_wr),
    .threshold (threshold),
    .frames    (n_eff),
    .ctl       (s1_ctl),
    .x         (s1_x),
    .y         (s1_y),
    .dx        (s1_dx),
    .dy        (s1_dy),
    .sum       (sum),
    .push      (push),
    .push_data (push_data)
  );

  fasl_result_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .res       (spots)
  );

  `FASL_ASSERT(a_pending_range, pending <= PW'(RES_DEPTH), "pending result count overflow")
  `FASL_ASSERT(a_col_range, WW'(col) < w_eff, "column outside image width")
  `FASL_ASSERT(a_row_range, HW'(row) < h_eff, "row outside image height")
  `FASL_ASSERT_IMPL(a_out_backed, spots.valid, pending != '0,
                    "result offered with no pending count")

endmodule

>>> rtl/fasl_sum_store.sv
// Per-pixel sum memory with registered read and read-modify-write accumulate.
// Forwards the word being written when the next read hits the same entry.
// Depends on fasl_pkg.
module fasl_sum_store import fasl_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  input  logic             wr_valid,
  input  logic             wr_first,
  input  logic [AW-1:0]    wr_addr,
  input  logic [PIX_W-1:0] wr_pix,
  output logic [SUM_W-1:0] sum
);

  logic [SUM_W-1:0] mem [DEPTH];
  logic [SUM_W-1:0] rd_data;
  logic             byp_hit;
  logic [SUM_W-1:0] byp_sum;
  logic [SUM_W-1:0] base;
  logic [SUM_W-1:0] sum_next;

  always_comb begin
    base     = byp_hit ? byp_sum : rd_data;
    sum_next = wr_first ? SUM_W'(wr_pix) : base + SUM_W'(wr_pix);
  end

  always_ff @(posedge clk) begin
    if (wr_valid) begin
      mem[wr_addr] <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      // a read that meets a write to the same entry takes the written word via bypass
      byp_hit <= wr_valid && (wr_addr == rd_addr);
      byp_sum <= sum_next;
    end
    sum <= sum_next;
  end

endmodule

>>> rtl/fasl_spot_track.sv
// Brightness test and nearest-to-center tracking of the bright pixel.
// Two stages: squares registered, then compare and update. Depends on fasl_pkg.
module fasl_spot_track import fasl_pkg::*; #(
  parameter int XW = 10,
  parameter int YW = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               restart,
  input  logic [PIX_W-1:0]   threshold,
  input  logic [FRAME_W-1:0] frames,
  input  pipe_ctl_t          ctl,
  input  logic [XW-1:0]      x,
  input  logic [YW-1:0]      y,
  input  logic [XW-1:0]      dx,
  input  logic [YW-1:0]      dy,
  input  logic [SUM_W-1:0]   sum,
  output logic               push,
  output result_t            push_data
);

  localparam int SQW = (XW > YW) ? 2 * XW : 2 * YW;
  localparam int DW  = SQW + 1;

  pipe_ctl_t        s2_ctl;
  logic [XW-1:0]    s2_x;
  logic [YW-1:0]    s2_y;
  logic [SQW-1:0]   sq_x;
  logic [SQW-1:0]   sq_y;
  logic [SUM_W-1:0] limit;

  logic          any_found, any_found_next;
  logic [DW-1:0] best_d, best_d_next;
  logic [XW-1:0] best_x, best_x_next;
  logic [YW-1:0] best_y, best_y_next;
  logic [DW-1:0] cand_d;
  logic          take;

  always_ff @(posedge clk) begin
    limit <= SUM_W'(threshold) * SUM_W'(frames);
    s2_x  <= x;
    s2_y  <= y;
    sq_x  <= SQW'(dx) * SQW'(dx);
    sq_y  <= SQW'(dy) * SQW'(dy);
    if (rst) begin
      s2_ctl <= '0;
    end else begin
      s2_ctl <= ctl;
    end
  end

  always_comb begin
    cand_d = DW'(sq_x) + DW'(sq_y);
    take = s2_ctl.valid && s2_ctl.last && (sum >= limit) &&
           (!any_found || cand_d < best_d);
    any_found_next = any_found;
    best_d_next    = best_d;
    best_x_next    = best_x;
    best_y_next    = best_y;
    if (take) begin
      any_found_next = 1'b1;
      best_d_next    = cand_d;
      best_x_next    = s2_x;
      best_y_next    = s2_y;
    end
    push = s2_ctl.valid && s2_ctl.eop;
    push_data.found         = any_found_next;
    push_data.spot_x        = any_found_next ? COORD_W'(best_x_next) : '0;
    push_data.spot_y        = any_found_next ? COORD_W'(best_y_next) : '0;
    push_data.spot_distance = any_found_next ? DIST_W'(best_d_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || restart || push) begin
      any_found <= 1'b0;
      best_d    <= '0;
      best_x    <= '0;
      best_y    <= '0;
    end else begin
      any_found <= any_found_next;
      best_d    <= best_d_next;
      best_x    <= best_x_next;
      best_y    <= best_y_next;
    end
  end

endmodule

>>> rtl/fasl_result_fifo.sv
// Small result queue in front of the output channel.
// Depends on fasl_pkg and the assertion macro header.
`include "frame_average_spot_locator_assert.svh"
module fasl_result_fifo import fasl_pkg::*; #(
  parameter int DEPTH = RES_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  fasl_result_if.source res
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t           slots [DEPTH];
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic [CNT_W-1:0]  count;
  logic              pop;
  result_t           head_word;

  assign pop       = res.valid && res.ready;
  assign head_word = slots[head];
  assign res.valid         = (count != '0);
  assign res.found         = head_word.found;
  assign res.spot_x        = head_word.spot_x;
  assign res.spot_y        = head_word.spot_y;
  assign res.spot_distance = head_word.spot_distance;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  `FASL_ASSERT(a_count_range, count <= CNT_W'(DEPTH), "result fifo count out of range")
  `FASL_ASSERT_IMPL(a_no_overflow, push, count < CNT_W'(DEPTH) || pop,
                    "result word pushed into full fifo")
  `FASL_ASSERT_IMPL(a_push_grows, push && !pop, ##1 count == $past(count) + 1'b1,
                    "result fifo count did not grow on push")

endmodule
